>>> hw/rtl/hdvf_pkg.sv
// Shared types and constants for the hashed duplicate vertex filter.
// No dependencies; used by hdvf_ctrl, hdvf_dp and the top level.
`default_nettype none

package hdvf_pkg;

  // Vertex split: low bits select the set, high bits form the tag.
  localparam int VERTEX_BITS   = 32;
  localparam int SET_BITS      = 14;
  localparam int SET_COUNT     = 1 << SET_BITS;
  localparam int TAG_BITS      = VERTEX_BITS - SET_BITS;
  localparam int WAY_COUNT_DEF = 4;

  // Input item kinds, carried on the slave-side tuser.
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DECIDE
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic lookup;    // capture vertex, start the set read
    logic ptr_clear; // return the replacement pointer to way zero
    logic sweep;     // write all ones to the set under the sweep counter
    logic insert;    // write the tag back, advance pointer, load result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last; // sweep counter sits on the last set
    logic hit;        // captured tag matches one of the ways
    logic out_free;   // result register can take a new item this cycle
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/hdvf_ctrl.sv
// Controller state machine for the duplicate vertex filter.
// Depends on hdvf_pkg; drives hdvf_dp through cmd_t, reads status_t.
`default_nettype none

module hdvf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_opcode,
  output logic             in_ready,
  input  hdvf_pkg::status_t status,
  output hdvf_pkg::cmd_t    cmd
);
  import hdvf_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_opcode == OP_CLEAR) ? ST_SWEEP : ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.hit || status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_SWEEP;
    endcase
  end

  // Outputs; ready is high throughout idle, so valid alone marks a take
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.lookup    = in_valid && (in_opcode == OP_FILTER);
        cmd.ptr_clear = in_valid && (in_opcode == OP_CLEAR);
      end
      ST_DECIDE: begin
        cmd.insert = !status.hit && status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/hdvf_dp.sv
// Datapath of the duplicate vertex filter: tag memory, compare, pointer,
// sweep counter and result register. Depends on hdvf_pkg; driven by hdvf_ctrl.
`default_nettype none

module hdvf_dp #(
  parameter int WAY_COUNT = hdvf_pkg::WAY_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [hdvf_pkg::VERTEX_BITS-1:0] in_vertex,
  input  hdvf_pkg::cmd_t                   cmd,
  output hdvf_pkg::status_t                status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hdvf_pkg::VERTEX_BITS-1:0] out_vertex
);
  import hdvf_pkg::*;

  localparam int ROW_BITS = WAY_COUNT * TAG_BITS;
  localparam int PTR_BITS = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

  // One row holds all ways of a set.
  logic [ROW_BITS-1:0]    mem [SET_COUNT];
  logic [ROW_BITS-1:0]    rdata;
  logic [ROW_BITS-1:0]    row_new;
  logic [ROW_BITS-1:0]    wdata;
  logic [SET_BITS-1:0]    waddr;
  logic                   wen;

  logic [VERTEX_BITS-1:0] vtx;
  logic [SET_BITS-1:0]    sweep_cnt;
  logic [PTR_BITS-1:0]    ptr;
  logic [PTR_BITS-1:0]    ptr_next;
  logic [TAG_BITS-1:0]    tag;
  logic [WAY_COUNT-1:0]   way_hit;

  assign tag = vtx[VERTEX_BITS-1:SET_BITS];

  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      way_hit[w] = (rdata[w*TAG_BITS +: TAG_BITS] == tag);
    end
  end

  always_comb begin
    row_new                         = rdata;
    row_new[ptr*TAG_BITS +: TAG_BITS] = tag;
  end

  assign ptr_next = (ptr == PTR_BITS'(WAY_COUNT - 1)) ? '0 : ptr + 1'b1;

  assign wen   = cmd.sweep || cmd.insert;
  assign waddr = cmd.sweep ? sweep_cnt : vtx[SET_BITS-1:0];
  assign wdata = cmd.sweep ? {ROW_BITS{1'b1}} : row_new;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (cmd.lookup) begin
      rdata <= mem[in_vertex[SET_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      vtx <= in_vertex;
    end
    if (cmd.insert) begin
      out_vertex <= vtx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Counter wraps back to zero on the last set.
      if (cmd.sweep) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
      if (cmd.ptr_clear) begin
        ptr <= '0;
      end else if (cmd.insert) begin
        ptr <= ptr_next;
      end
      if (cmd.insert) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.sweep_last = (sweep_cnt == SET_BITS'(SET_COUNT - 1));
  assign status.hit        = |way_hit;
  assign status.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

>>> hw/rtl/hashed_duplicate_vertex_filter.sv
// Hashed duplicate vertex filter, top level: joins controller and datapath.
// Depends on hdvf_pkg, hdvf_ctrl and hdvf_dp.
//
// Removes repeated vertex indices from a stream using a set-associative
// seen-table. Bits 13:0 of a vertex pick one of 16384 sets; bits 31:14 form
// an 18-bit tag compared with every way of the set (four by default). On a
// miss the vertex is passed on and its tag replaces the way named by one
// global round-robin pointer, which then advances; on a hit nothing leaves.
// A clear item (tuser high) sets every tag to all ones and returns the
// pointer to way zero; a vertex whose tag is all ones therefore reads as
// seen and is dropped while any way of its set still holds all ones. The
// table is one row per set in a single memory with a registered read, so a
// vertex's set is first read into a register, then compared and written
// back. Reset and each clear item start a sweep that writes all ones to one
// set per cycle, during which no item is taken. A finished result waits in
// an output register while the next vertex is taken; a missing vertex
// stalls only while that register is still full.
`default_nettype none

module hashed_duplicate_vertex_filter #(
  parameter int WAY_COUNT = hdvf_pkg::WAY_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] vertex_in
  input  logic        s_axis_tuser,  // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [31:0] vertex_out
);
  import hdvf_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence sweep, lookup and write-back.
  hdvf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_opcode (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the tag table, pointer and result register.
  hdvf_dp #(
    .WAY_COUNT (WAY_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_vertex  (s_axis_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_vertex (m_axis_tdata)
  );

endmodule

`default_nettype wire
